// File: rtl/core/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared types and constants for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_HDR_INC = 2'd1;
  localparam logic [1:0] ST_PAY_INC = 2'd2;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_CODE_16   = 7'd126;
  localparam logic [3:0] EXT_BYTES_16  = 4'd2;
  localparam logic [3:0] EXT_BYTES_64  = 4'd8;
  localparam logic [3:0] KEY_BYTES     = 4'd4;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_payload;
    logic        fin_flag;
    logic [3:0]  frame_opcode;
    logic        was_masked;
    logic [63:0] payload_length;
    logic        frame_done;
    logic [1:0]  status;
  } wsfp_res_t;

endpackage

// File: rtl/core/wsfp_decode.sv
// ----------------------------------------------------------------------------
// wsfp_decode
// Frame state and per-byte decode: header fields, extended length, mask key
// capture and payload unmasking. One byte per step.
// ----------------------------------------------------------------------------
module wsfp_decode import wsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  output logic       res_valid,
  output wsfp_res_t  res
);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXT   = 3'd2,
    PH_KEY   = 3'd3,
    PH_PAY   = 3'd4,
    PH_DRAIN = 3'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  ext_count_r, ext_count_nxt;
  logic        fin_bit_r, fin_bit_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        mask_bit_r, mask_bit_nxt;
  logic [6:0]  length_code_r, length_code_nxt;
  logic [63:0] length_value_r, length_value_nxt;
  logic [31:0] key_bytes_r, key_bytes_nxt;
  logic [63:0] payload_index_r, payload_index_nxt;

  logic [3:0]  ext_inc;
  logic [3:0]  ext_target;
  logic [63:0] pidx_inc;
  logic [7:0]  key_byte;
  logic [7:0]  outb;
  logic        is_pay;
  logic        done;
  logic [1:0]  status;
  logic        hdr_complete;

  always_comb begin
    phase_nxt         = phase_r;
    ext_count_nxt     = ext_count_r;
    fin_bit_nxt       = fin_bit_r;
    opcode_nxt        = opcode_r;
    mask_bit_nxt      = mask_bit_r;
    length_code_nxt   = length_code_r;
    length_value_nxt  = length_value_r;
    key_bytes_nxt     = key_bytes_r;
    payload_index_nxt = payload_index_r;
    outb              = data_byte;
    is_pay            = 1'b0;
    done              = 1'b0;
    status            = ST_OK;
    res_valid         = 1'b1;

    ext_inc    = ext_count_r + 4'd1;
    ext_target = (length_code_r == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
    pidx_inc   = payload_index_r + 64'd1;
    key_byte   = key_bytes_r[{payload_index_r[1:0], 3'b000} +: 8];

    case (phase_r)
      PH_DRAIN: begin
        // trailing bytes after the frame give no item
        res_valid = 1'b0;
        if (buffer_end) begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_HDR1: begin
        mask_bit_nxt    = data_byte[7];
        length_code_nxt = data_byte[6:0];
        ext_count_nxt   = 4'd0;
        if (data_byte[6:0] <= LEN_MAX_SHORT) begin
          length_value_nxt = {57'd0, data_byte[6:0]};
          if (data_byte[7]) begin
            phase_nxt = PH_KEY;
          end else if (data_byte[6:0] == 7'd0) begin
            phase_nxt = PH_DRAIN;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_PAY;
          end
        end else begin
          phase_nxt = PH_EXT;
        end
      end
      PH_EXT: begin
        length_value_nxt = {length_value_r[55:0], data_byte};
        ext_count_nxt    = ext_inc;
        if (ext_inc == ext_target) begin
          ext_count_nxt = 4'd0;
          if (mask_bit_r) begin
            phase_nxt = PH_KEY;
          end else if (length_value_nxt == 64'd0) begin
            phase_nxt = PH_DRAIN;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
      end
      PH_KEY: begin
        key_bytes_nxt[{ext_count_r[1:0], 3'b000} +: 8] =
          key_bytes_r[{ext_count_r[1:0], 3'b000} +: 8] | data_byte;
        ext_count_nxt = ext_inc;
        if (ext_inc >= KEY_BYTES) begin
          ext_count_nxt = 4'd0;
          if (length_value_r == 64'd0) begin
            phase_nxt = PH_DRAIN;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        is_pay = 1'b1;
        if (mask_bit_r) begin
          outb = data_byte ^ key_byte;
        end
        payload_index_nxt = pidx_inc;
        if (pidx_inc == length_value_r) begin
          phase_nxt = PH_DRAIN;
          done      = 1'b1;
        end
      end
      default: begin
        // first header byte; unused phase codes land here too
        fin_bit_nxt       = data_byte[7];
        opcode_nxt        = data_byte[3:0];
        mask_bit_nxt      = 1'b0;
        length_code_nxt   = 7'd0;
        length_value_nxt  = 64'd0;
        key_bytes_nxt     = 32'd0;
        payload_index_nxt = 64'd0;
        ext_count_nxt     = 4'd0;
        phase_nxt         = PH_HDR1;
      end
    endcase

    hdr_complete = (phase_nxt == PH_PAY) || (phase_nxt == PH_DRAIN);

    if (buffer_end && res_valid) begin
      if (!done) begin
        done   = 1'b1;
        status = hdr_complete ? ST_PAY_INC : ST_HDR_INC;
      end
      phase_nxt     = PH_HDR0;
      ext_count_nxt = 4'd0;
    end

    res.out_byte       = outb;
    res.is_payload     = is_pay;
    res.fin_flag       = fin_bit_nxt;
    res.frame_opcode   = opcode_nxt;
    res.was_masked     = mask_bit_nxt;
    res.payload_length = hdr_complete ? length_value_nxt : 64'd0;
    res.frame_done     = done;
    res.status         = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_HDR0;
      ext_count_r     <= 4'd0;
      fin_bit_r       <= 1'b0;
      opcode_r        <= 4'd0;
      mask_bit_r      <= 1'b0;
      length_code_r   <= 7'd0;
      length_value_r  <= 64'd0;
      key_bytes_r     <= 32'd0;
      payload_index_r <= 64'd0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      ext_count_r     <= ext_count_nxt;
      fin_bit_r       <= fin_bit_nxt;
      opcode_r        <= opcode_nxt;
      mask_bit_r      <= mask_bit_nxt;
      length_code_r   <= length_code_nxt;
      length_value_r  <= length_value_nxt;
      key_bytes_r     <= key_bytes_nxt;
      payload_index_r <= payload_index_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_err_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.status != ST_OK) |-> res.frame_done)
    else $error("error status without frame_done");

  a_pay_not_hdr_err: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.is_payload) |-> (res.status != ST_HDR_INC))
    else $error("payload item flagged as incomplete header");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step && buffer_end) |=> (phase_r == PH_HDR0))
    else $error("buffer end did not return to first header byte");
`endif

endmodule

// File: rtl/core/websocket_frame_parser.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Decodes one WebSocket frame per received buffer, one byte per cycle when not stalled.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_stall   in_data_byte, in_buffer_end
//  out       out_valid / out_stall out_out_byte ... out_status (one item max)
//
//  One byte per cycle sustained while out_stall is low. out_valid rises once the
//  byte has passed the input register and been decoded into the result register.
//  Bytes after the frame end give no item. rst_n is synchronous, active low.
//  out_stall holds the result register; the input register still takes one
//  more item if it is empty, after which in_stall rises.
// ----------------------------------------------------------------------------
module websocket_frame_parser import wsfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_is_payload,
  output logic        out_fin_flag,
  output logic [3:0]  out_frame_opcode,
  output logic        out_was_masked,
  output logic [63:0] out_payload_length,
  output logic        out_frame_done,
  output logic [1:0]  out_status
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;
  logic       out_vld_r;
  wsfp_res_t  res_r;
  wsfp_res_t  res;
  logic       res_valid;
  logic       fire;

  // decode a held byte whenever the result register can take an item
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  wsfp_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (fire),
    .data_byte  (in_byte_r),
    .buffer_end (in_end_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= res_valid;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
      in_end_r  <= in_buffer_end;
    end
    if (fire && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_out_byte       = res_r.out_byte;
  assign out_is_payload     = res_r.is_payload;
  assign out_fin_flag       = res_r.fin_flag;
  assign out_frame_opcode   = res_r.frame_opcode;
  assign out_was_masked     = res_r.was_masked;
  assign out_payload_length = res_r.payload_length;
  assign out_frame_done     = res_r.frame_done;
  assign out_status         = res_r.status;

endmodule
